@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mpe_pkg.sv @@
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared widths and reset values for the modular polynomial evaluator.
// ----------------------------------------------------------------------------
package mpe_pkg;

    localparam int unsigned DATA_W        = 64;
    localparam int unsigned WORD_BITS_DEF = 64;
    localparam logic [DATA_W-1:0] MODULUS_RESET = 64'd2;

endpackage

@@ rtl/mpe_if.sv @@
// ----------------------------------------------------------------------------
// mpe_if
// Valid/ready channels: coefficient input, result output, modulus write.
// ----------------------------------------------------------------------------
interface mpe_in_if;
    logic                        valid;
    logic                        ready;
    logic [mpe_pkg::DATA_W-1:0]  coeff;
    logic [mpe_pkg::DATA_W-1:0]  point;
    logic                        first;
    logic                        last;

    modport source (output valid, output coeff, output point, output first,
                    output last, input ready);
    modport sink   (input valid, input coeff, input point, input first,
                    input last, output ready);
endinterface

interface mpe_out_if;
    logic                        valid;
    logic                        ready;
    logic [mpe_pkg::DATA_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface mpe_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mpe_pkg::DATA_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/mpe_modadd.sv @@
// ----------------------------------------------------------------------------
// mpe_modadd
// Shared modular adder: (x + y + cin) mod n for x, y below n; n of zero wraps.
// ----------------------------------------------------------------------------
module mpe_modadd #(
    parameter int unsigned WORD_BITS = mpe_pkg::WORD_BITS_DEF
) (
    input  logic [WORD_BITS-1:0] x,
    input  logic [WORD_BITS-1:0] y,
    input  logic                 cin,
    input  logic [WORD_BITS-1:0] n,
    output logic [WORD_BITS-1:0] res
);

    logic [WORD_BITS:0] sum;
    logic [WORD_BITS:0] diff;

    always_comb
    begin
        sum  = {1'b0, x} + {1'b0, y} + {{WORD_BITS{1'b0}}, cin};
        diff = sum - {1'b0, n};
        if (n == '0)
        begin
            res = sum[WORD_BITS-1:0];
        end
        else if (sum >= {1'b0, n})
        begin
            res = diff[WORD_BITS-1:0];
        end
        else
        begin
            res = sum[WORD_BITS-1:0];
        end
    end

endmodule

@@ rtl/mpe_seq.sv @@
// ----------------------------------------------------------------------------
// mpe_seq
// Horner sequencer: bit-serial reductions and double-and-add products,
// all through the one shared modular adder.
// ----------------------------------------------------------------------------
module mpe_seq #(
    parameter int unsigned WORD_BITS = mpe_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mpe_in_if.sink               item,
    input  logic [WORD_BITS-1:0] n,
    input  logic                 slot_free,
    output logic                 emit,
    output logic [WORD_BITS-1:0] acc_value
);

    localparam int unsigned CW = $clog2(WORD_BITS);
    localparam logic [CW-1:0] CNT_LAST = CW'(WORD_BITS - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RCF  = 8'b0000_0010,
        S_RACC = 8'b0000_0100,
        S_RPT  = 8'b0000_1000,
        S_MDBL = 8'b0001_0000,
        S_MADD = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] pt_reg, pt_next;
    logic                 first_reg, first_next;
    logic                 last_reg, last_next;
    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [WORD_BITS-1:0] sh_reg, sh_next;
    logic [WORD_BITS-1:0] cf_reg, cf_next;

    logic [WORD_BITS-1:0] u_x, u_y, u_res;
    logic                 u_cin;
    logic                 accept;
    logic [WORD_BITS-1:0] sh_shift;

    mpe_modadd #(.WORD_BITS(WORD_BITS)) u_add (
        .x   (u_x),
        .y   (u_y),
        .cin (u_cin),
        .n   (n),
        .res (u_res)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign emit       = (state_reg == S_EMIT) && slot_free;
    assign acc_value  = acc_reg;
    assign sh_shift   = {sh_reg[WORD_BITS-2:0], 1'b0};

    always_comb
    begin
        u_x   = r_reg;
        u_y   = '0;
        u_cin = 1'b0;
        unique case (state_reg)
            S_RCF, S_RACC, S_RPT:
            begin
                u_y   = r_reg;
                u_cin = sh_reg[WORD_BITS-1];
            end
            S_MDBL: u_y = r_reg;
            S_MADD: u_y = sh_reg[WORD_BITS-1] ? acc_reg : '0;
            S_FIN:  u_y = cf_reg;
            default: u_y = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        pt_next    = pt_reg;
        first_next = first_reg;
        last_next  = last_reg;
        r_next     = r_reg;
        sh_next    = sh_reg;
        cf_next    = cf_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sh_next    = item.coeff[WORD_BITS-1:0];
                    r_next     = '0;
                    cnt_next   = CNT_LAST;
                    first_next = item.first;
                    last_next  = item.last;
                    if (item.first)
                    begin
                        pt_next = item.point[WORD_BITS-1:0];
                    end
                    state_next = S_RCF;
                end
            end
            S_RCF:
            begin
                r_next   = u_res;
                sh_next  = sh_shift;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    cf_next = u_res;
                    if (first_reg)
                    begin
                        acc_next   = u_res;
                        state_next = last_reg ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        sh_next    = acc_reg;
                        r_next     = '0;
                        cnt_next   = CNT_LAST;
                        state_next = S_RACC;
                    end
                end
            end
            S_RACC:
            begin
                r_next   = u_res;
                sh_next  = sh_shift;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    acc_next   = u_res;
                    sh_next    = pt_reg;
                    r_next     = '0;
                    cnt_next   = CNT_LAST;
                    state_next = S_RPT;
                end
            end
            S_RPT:
            begin
                r_next   = u_res;
                sh_next  = sh_shift;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    sh_next    = u_res;
                    r_next     = '0;
                    cnt_next   = CNT_LAST;
                    state_next = S_MDBL;
                end
            end
            S_MDBL:
            begin
                r_next     = u_res;
                state_next = S_MADD;
            end
            S_MADD:
            begin
                r_next  = u_res;
                sh_next = sh_shift;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_MDBL;
                end
            end
            S_FIN:
            begin
                acc_next   = u_res;
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            pt_reg    <= '0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            pt_reg    <= pt_next;
            first_reg <= first_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        sh_reg <= sh_next;
        cf_reg <= cf_next;
    end

endmodule

@@ rtl/modular_polynomial_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// modular_polynomial_evaluator_top
// Horner evaluation of a streamed polynomial modulo a configured modulus.
// ----------------------------------------------------------------------------
// Coefficients arrive highest degree first on the item channel; the beat
// marked first also carries the evaluation point, the beat marked last
// produces one result beat. All arithmetic runs through a single shared
// modular adder, one step per cycle, with a WORD_BITS-bit datapath
// (coefficient, point and modulus use their low WORD_BITS bits; a modulus of
// zero means 2^WORD_BITS). A leading coefficient is only reduced; every other
// coefficient goes through reduction of coefficient, accumulator and point,
// then a double-and-add product and one final add. A last beat then passes
// through the emit state, which waits for a free output slot, then hands
// the value to the output register; that register holds it while the next
// beat is already accepted. The modulus register takes writes at any time
// but must only be written while the block is idle.
// ----------------------------------------------------------------------------
module modular_polynomial_evaluator_top #(
    parameter int unsigned WORD_BITS = mpe_pkg::WORD_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    mpe_in_if.sink   item,
    mpe_out_if.source result,
    mpe_cfg_if.sink  cfg
);

    logic [WORD_BITS-1:0]       n_reg;
    logic                       valid_reg;
    logic [mpe_pkg::DATA_W-1:0] value_reg;
    logic                       slot_free;
    logic                       emit;
    logic [WORD_BITS-1:0]       acc_value;

    assign cfg.ready    = 1'b1;
    assign slot_free    = !valid_reg || result.ready;
    assign result.valid = valid_reg;
    assign result.value = value_reg;

    mpe_seq #(.WORD_BITS(WORD_BITS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .n         (n_reg),
        .slot_free (slot_free),
        .emit      (emit),
        .acc_value (acc_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= mpe_pkg::MODULUS_RESET[WORD_BITS-1:0];
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                n_reg <= cfg.data[WORD_BITS-1:0];
            end
            if (emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg <= mpe_pkg::DATA_W'(acc_value);
        end
    end

endmodule

@@ rtl/mpe_checker.sv @@
// ----------------------------------------------------------------------------
// mpe_checker
// Port-level checks on the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpe_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_ready,
    input logic                       item_last,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic [mpe_pkg::DATA_W-1:0] result_value
);

    `ASSERT_NEXT(a_res_hold, clk, rst_n, result_valid && !result_ready, result_valid, "result beat dropped while stalled")
    `ASSERT_NEXT(a_res_stable, clk, rst_n, result_valid && !result_ready, $stable(result_value), "result value changed while stalled")
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_valid && item_ready, !item_ready, "ready stayed high after an accepted beat")
    `ASSERT_NEXT(a_no_spurious_result, clk, rst_n, item_valid && item_ready && !item_last && !result_valid, !result_valid, "result appeared without a last beat")

endmodule

bind modular_polynomial_evaluator_top mpe_checker u_mpe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_last    (item.last),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_value (result.value)
);
